### hw/rtl/hs3_pkg.sv
package hs3_pkg;

  // Grid and number format.
  localparam int MAX_EDGE  = 64;
  localparam int TEMP_BITS = 25;

  localparam int EDGE_W  = $clog2(MAX_EDGE + 1);
  localparam int COORD_W = $clog2(MAX_EDGE);
  localparam int PLANE   = MAX_EDGE * MAX_EDGE;
  localparam int PLANE_W = $clog2(PLANE + 1);
  localparam int PTR_W   = $clog2(PLANE);

  // Six-neighbor sum plus rounding offset, and the reciprocal of six.
  localparam int SUM_W       = TEMP_BITS + 3;
  localparam int RECIP_SHIFT = SUM_W + 2;
  localparam int RECIP_W     = RECIP_SHIFT - 2;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / 6;
  localparam logic [RECIP_W-1:0] RECIP_SIXTH = RECIP_W'(RECIP_FULL);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = EDGE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_SIZE,
    REG_SOURCE_X,
    REG_SOURCE_Y,
    REG_SOURCE_Z
  } cfg_reg_e;

  localparam logic [EDGE_W-1:0]  EDGE_MIN     = EDGE_W'(2);
  localparam logic [EDGE_W-1:0]  EDGE_MAX     = EDGE_W'(MAX_EDGE);
  localparam logic [EDGE_W-1:0]  EDGE_RESET   = EDGE_W'(MAX_EDGE);
  localparam logic [COORD_W-1:0] SOURCE_RESET = COORD_W'(2);

  typedef logic [TEMP_BITS-1:0] temp_t;

  // The seven stencil taps of one voxel.
  typedef struct packed {
    temp_t up_z;
    temp_t up_y;
    temp_t up_x;
    temp_t centre;
    temp_t dn_x;
    temp_t dn_y;
    temp_t dn_z;
  } taps_t;

  // Boundary and role flags of the voxel whose taps are in the window.
  typedef struct packed {
    logic has_up_z;
    logic has_up_y;
    logic has_up_x;
    logic has_dn_x;
    logic has_dn_y;
    logic has_dn_z;
    logic is_source;
    logic last;
  } voxel_meta_t;

  // Lengths of the four delay lines for the current edge size.
  typedef struct packed {
    logic [PLANE_W-1:0] up_y;
    logic [PLANE_W-1:0] up_x;
    logic [PLANE_W-1:0] dn_y;
    logic [PLANE_W-1:0] dn_z;
  } delay_len_t;

endpackage

### hw/rtl/hs3_if.sv
interface hs3_in_if;
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [hs3_pkg::TEMP_BITS-1:0] temperature_in;

  modport source (output valid, output mode, output temperature_in, input ready);
  modport sink (input valid, input mode, input temperature_in, output ready);
endinterface

interface hs3_out_if;
  logic                  valid;
  logic                  ready;
  logic [hs3_pkg::TEMP_BITS-1:0] temperature_out;
  logic                  last_voxel;

  modport source (output valid, output temperature_out, output last_voxel, input ready);
  modport sink (input valid, input temperature_out, input last_voxel, output ready);
endinterface

### hw/rtl/hs3_ram.sv
module hs3_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: the read returns the entry as it was before this write.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q        <= mem_q[addr_i];
      mem_q[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/hs3_window.sv
module hs3_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic                restart_i,
  input  hs3_pkg::delay_len_t len_i,
  input  hs3_pkg::temp_t      data_i,
  output hs3_pkg::taps_t      taps_o
);

  logic [hs3_pkg::PTR_W-1:0]   ptr_up_y_q, ptr_up_y_d;
  logic [hs3_pkg::PTR_W-1:0]   ptr_up_x_q, ptr_up_x_d;
  logic [hs3_pkg::COORD_W-1:0] ptr_dn_y_q, ptr_dn_y_d;
  logic [hs3_pkg::PTR_W-1:0]   ptr_dn_z_q, ptr_dn_z_d;

  hs3_pkg::temp_t rd_up_y, rd_up_x, rd_dn_y, rd_dn_z;
  hs3_pkg::temp_t up_z_q, centre_q, dn_x_q;

  // Each delay line is a circular buffer whose pointer wraps at its length.
  always_comb begin
    ptr_up_y_d = ptr_up_y_q + 1'b1;
    ptr_up_x_d = ptr_up_x_q + 1'b1;
    ptr_dn_y_d = ptr_dn_y_q + 1'b1;
    ptr_dn_z_d = ptr_dn_z_q + 1'b1;
    if ({1'b0, ptr_up_y_q} == len_i.up_y - 1'b1) ptr_up_y_d = '0;
    if ({1'b0, ptr_up_x_q} == len_i.up_x - 1'b1) ptr_up_x_d = '0;
    if (hs3_pkg::PLANE_W'(ptr_dn_y_q) == len_i.dn_y - 1'b1) ptr_dn_y_d = '0;
    if ({1'b0, ptr_dn_z_q} == len_i.dn_z - 1'b1) ptr_dn_z_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_up_y_q <= '0;
      ptr_up_x_q <= '0;
      ptr_dn_y_q <= '0;
      ptr_dn_z_q <= '0;
    end else if (restart_i) begin
      ptr_up_y_q <= '0;
      ptr_up_x_q <= '0;
      ptr_dn_y_q <= '0;
      ptr_dn_z_q <= '0;
    end else if (shift_i) begin
      ptr_up_y_q <= ptr_up_y_d;
      ptr_up_x_q <= ptr_up_x_d;
      ptr_dn_y_q <= ptr_dn_y_d;
      ptr_dn_z_q <= ptr_dn_z_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      up_z_q   <= data_i;
      centre_q <= rd_up_x;
      dn_x_q   <= centre_q;
    end
  end

  hs3_ram #(.DEPTH(hs3_pkg::PLANE), .WIDTH(hs3_pkg::TEMP_BITS)) u_ram_up_y (
    .clk_i  (clk_i),
    .en_i   (shift_i),
    .addr_i (ptr_up_y_q),
    .wdata_i(data_i),
    .rdata_o(rd_up_y)
  );

  hs3_ram #(.DEPTH(hs3_pkg::PLANE), .WIDTH(hs3_pkg::TEMP_BITS)) u_ram_up_x (
    .clk_i  (clk_i),
    .en_i   (shift_i),
    .addr_i (ptr_up_x_q),
    .wdata_i(data_i),
    .rdata_o(rd_up_x)
  );

  hs3_ram #(.DEPTH(hs3_pkg::MAX_EDGE), .WIDTH(hs3_pkg::TEMP_BITS)) u_ram_dn_y (
    .clk_i  (clk_i),
    .en_i   (shift_i),
    .addr_i (ptr_dn_y_q),
    .wdata_i(rd_up_x),
    .rdata_o(rd_dn_y)
  );

  hs3_ram #(.DEPTH(hs3_pkg::PLANE), .WIDTH(hs3_pkg::TEMP_BITS)) u_ram_dn_z (
    .clk_i  (clk_i),
    .en_i   (shift_i),
    .addr_i (ptr_dn_z_q),
    .wdata_i(rd_up_x),
    .rdata_o(rd_dn_z)
  );

  assign taps_o.up_z   = up_z_q;
  assign taps_o.up_y   = rd_up_y;
  assign taps_o.up_x   = rd_up_x;
  assign taps_o.centre = centre_q;
  assign taps_o.dn_x   = dn_x_q;
  assign taps_o.dn_y   = rd_dn_y;
  assign taps_o.dn_z   = rd_dn_z;

endmodule

### hw/rtl/hs3_update.sv
module hs3_update (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  hs3_pkg::taps_t       taps_i,
  input  hs3_pkg::voxel_meta_t meta_i,
  hs3_out_if.source            out_ch
);

  logic en2, en3, out_en;

  logic                      v2_q, v3_q, out_v_q;
  logic [hs3_pkg::SUM_W-1:0] sum2_q, sum3_q;
  hs3_pkg::temp_t            centre2_q, centre3_q, out_temp_q;
  logic                      src2_q, src3_q, last2_q, last3_q, out_last_q;
  logic [hs3_pkg::PROD_W-1:0] prod3_q;

  logic [hs3_pkg::SUM_W-1:0]  sum2_d;
  logic [hs3_pkg::QUOT_W-1:0] quot_est, quot_fix;
  logic [hs3_pkg::SUM_W-1:0]  rem;
  hs3_pkg::temp_t             out_temp_d;

  assign out_en  = !out_v_q || out_ch.ready;
  assign en3     = !v3_q || out_en;
  assign en2     = !v2_q || en3;
  assign ready_o = en2;

  // A neighbor outside the grid is replaced by the center value.
  always_comb begin
    sum2_d = hs3_pkg::SUM_W'(3);
    sum2_d += hs3_pkg::SUM_W'(meta_i.has_up_z ? taps_i.up_z : taps_i.centre);
    sum2_d += hs3_pkg::SUM_W'(meta_i.has_up_y ? taps_i.up_y : taps_i.centre);
    sum2_d += hs3_pkg::SUM_W'(meta_i.has_up_x ? taps_i.up_x : taps_i.centre);
    sum2_d += hs3_pkg::SUM_W'(meta_i.has_dn_x ? taps_i.dn_x : taps_i.centre);
    sum2_d += hs3_pkg::SUM_W'(meta_i.has_dn_y ? taps_i.dn_y : taps_i.centre);
    sum2_d += hs3_pkg::SUM_W'(meta_i.has_dn_z ? taps_i.dn_z : taps_i.centre);
  end

  // The reciprocal estimate is at most one low; one compare fixes it.
  always_comb begin
    quot_est = prod3_q[hs3_pkg::PROD_W-1:hs3_pkg::RECIP_SHIFT];
    rem      = sum3_q - hs3_pkg::SUM_W'(quot_est) * hs3_pkg::SUM_W'(6);
    quot_fix = (rem >= hs3_pkg::SUM_W'(6)) ? quot_est + 1'b1 : quot_est;
    out_temp_d = src3_q ? centre3_q : hs3_pkg::TEMP_BITS'(quot_fix);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en2)    v2_q    <= valid_i;
      if (en3)    v3_q    <= v2_q;
      if (out_en) out_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sum2_q    <= sum2_d;
      centre2_q <= taps_i.centre;
      src2_q    <= meta_i.is_source;
      last2_q   <= meta_i.last;
    end
    if (en3) begin
      prod3_q   <= hs3_pkg::PROD_W'(sum2_q) * hs3_pkg::PROD_W'(hs3_pkg::RECIP_SIXTH);
      sum3_q    <= sum2_q;
      centre3_q <= centre2_q;
      src3_q    <= src2_q;
      last3_q   <= last2_q;
    end
    if (out_en) begin
      out_temp_q <= out_temp_d;
      out_last_q <= last3_q;
    end
  end

  assign out_ch.valid           = out_v_q;
  assign out_ch.temperature_out = out_temp_q;
  assign out_ch.last_voxel      = out_last_q;

endmodule

### hw/rtl/heat_stencil_3d_sweep.sv
// One Jacobi step of 3D heat diffusion on an N x N x N grid, 7-point stencil.
// Voxel temperatures (unsigned 9.16 Kelvin) enter on in_ch in raster order,
// x fastest, with mode low. Each updated voxel leaves on out_ch in raster
// order as the mean of its six neighbors, rounded half up; a neighbor outside
// the grid takes the center value and the source voxel passes unchanged.
// The result for voxel p is formed when voxel p + N*N arrives, so results lag
// the input stream by one plane; after the last voxel the host sends N*N
// items with mode high to drain the last plane. last_voxel marks the final
// voxel, after which the next voxel item starts a new sweep.
// Throughput is one item per cycle: four read-first delay-line memories hold
// two planes and each does one read and one write per item. A full output
// register does not stop input: three pipeline stages plus the tap stage
// buffer results before in_ch.ready falls under a stalled receiver. Reset
// clears positions and restores edge 64 and source (2,2,2); the plane
// memories are not cleared and need no clearing pass. Writing edge_size
// restarts the sweep; configuration must be written only while the block is
// idle, and the block itself does not enforce it.
module heat_stencil_3d_sweep (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hs3_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hs3_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  hs3_in_if.sink                           in_ch,
  hs3_out_if.source                        out_ch
);

  // Configuration registers.
  logic [hs3_pkg::EDGE_W-1:0]  edge_q;
  logic [hs3_pkg::COORD_W-1:0] src_x_q, src_y_q, src_z_q;

  // Stream positions.
  logic [hs3_pkg::COORD_W-1:0] in_x_q, in_y_q, in_z_q, in_x_d, in_y_d, in_z_d;
  logic [hs3_pkg::COORD_W-1:0] out_x_q, out_y_q, out_z_q, out_x_d, out_y_d, out_z_d;
  logic                        in_done_q, in_done_d;

  // Tap stage: the window taps plus the flags of the voxel they belong to.
  logic                 v1_q, v1_d;
  hs3_pkg::voxel_meta_t meta1_q, meta_d;
  hs3_pkg::taps_t       taps;
  hs3_pkg::delay_len_t  len;

  logic [hs3_pkg::EDGE_W-1:0]  edge_n;
  logic [hs3_pkg::COORD_W-1:0] n_m1;
  logic [hs3_pkg::PLANE_W-1:0] plane_n;

  logic in_acc, shift, emit, restart, in_last, out_last, upd_ready;

  // The edge register is clamped into the supported range.
  always_comb begin
    if (edge_q < hs3_pkg::EDGE_MIN) begin
      edge_n = hs3_pkg::EDGE_MIN;
    end else if (edge_q > hs3_pkg::EDGE_MAX) begin
      edge_n = hs3_pkg::EDGE_MAX;
    end else begin
      edge_n = edge_q;
    end
  end

  assign n_m1    = hs3_pkg::COORD_W'(edge_n - 1'b1);
  assign plane_n = hs3_pkg::PLANE_W'(hs3_pkg::PLANE_W'(edge_n) * hs3_pkg::PLANE_W'(edge_n));

  // Taps relative to the newest voxel: +Y is one plane minus one row back,
  // +X one plane minus one voxel back; the center and -X follow in registers,
  // -Y and -Z hang off the +X line one row and one plane further back.
  assign len.up_y = plane_n - hs3_pkg::PLANE_W'(edge_n);
  assign len.up_x = plane_n - 1'b1;
  assign len.dn_y = hs3_pkg::PLANE_W'(edge_n);
  assign len.dn_z = plane_n;

  assign in_ch.ready = !v1_q || upd_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // A voxel item shifts while the grid is still arriving; a flush item shifts
  // while draining. Anything else is taken and dropped.
  assign shift = in_acc && (in_ch.mode == in_done_q);
  assign emit  = shift && (in_done_q || (in_z_q != '0));

  assign restart = cfg_we_i && (hs3_pkg::cfg_reg_e'(cfg_idx_i) == hs3_pkg::REG_EDGE_SIZE);

  assign in_last  = (in_x_q == n_m1) && (in_y_q == n_m1) && (in_z_q == n_m1);
  assign out_last = (out_x_q == n_m1) && (out_y_q == n_m1) && (out_z_q == n_m1);

  always_comb begin
    meta_d.has_up_z  = out_z_q != n_m1;
    meta_d.has_up_y  = out_y_q != n_m1;
    meta_d.has_up_x  = out_x_q != n_m1;
    meta_d.has_dn_x  = out_x_q != '0;
    meta_d.has_dn_y  = out_y_q != '0;
    meta_d.has_dn_z  = out_z_q != '0;
    meta_d.is_source = (out_x_q == src_x_q) && (out_y_q == src_y_q) && (out_z_q == src_z_q);
    meta_d.last      = out_last;
  end

  always_comb begin
    in_x_d    = in_x_q;
    in_y_d    = in_y_q;
    in_z_d    = in_z_q;
    out_x_d   = out_x_q;
    out_y_d   = out_y_q;
    out_z_d   = out_z_q;
    in_done_d = in_done_q;

    if (shift && !in_ch.mode) begin
      if (in_last) begin
        in_done_d = 1'b1;
      end else if (in_x_q == n_m1) begin
        in_x_d = '0;
        if (in_y_q == n_m1) begin
          in_y_d = '0;
          in_z_d = in_z_q + 1'b1;
        end else begin
          in_y_d = in_y_q + 1'b1;
        end
      end else begin
        in_x_d = in_x_q + 1'b1;
      end
    end

    if (emit) begin
      if (out_last) begin
        // The final voxel of the sweep returns every position to the origin.
        in_x_d    = '0;
        in_y_d    = '0;
        in_z_d    = '0;
        out_x_d   = '0;
        out_y_d   = '0;
        out_z_d   = '0;
        in_done_d = 1'b0;
      end else if (out_x_q == n_m1) begin
        out_x_d = '0;
        if (out_y_q == n_m1) begin
          out_y_d = '0;
          out_z_d = out_z_q + 1'b1;
        end else begin
          out_y_d = out_y_q + 1'b1;
        end
      end else begin
        out_x_d = out_x_q + 1'b1;
      end
    end

    if (restart) begin
      in_x_d    = '0;
      in_y_d    = '0;
      in_z_d    = '0;
      out_x_d   = '0;
      out_y_d   = '0;
      out_z_d   = '0;
      in_done_d = 1'b0;
    end
  end

  always_comb begin
    v1_d = v1_q;
    if (shift) begin
      v1_d = emit;
    end else if (upd_ready) begin
      v1_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q    <= hs3_pkg::EDGE_RESET;
      src_x_q   <= hs3_pkg::SOURCE_RESET;
      src_y_q   <= hs3_pkg::SOURCE_RESET;
      src_z_q   <= hs3_pkg::SOURCE_RESET;
      in_x_q    <= '0;
      in_y_q    <= '0;
      in_z_q    <= '0;
      out_x_q   <= '0;
      out_y_q   <= '0;
      out_z_q   <= '0;
      in_done_q <= 1'b0;
      v1_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (hs3_pkg::cfg_reg_e'(cfg_idx_i))
          hs3_pkg::REG_EDGE_SIZE: edge_q  <= cfg_data_i;
          hs3_pkg::REG_SOURCE_X:  src_x_q <= cfg_data_i[hs3_pkg::COORD_W-1:0];
          hs3_pkg::REG_SOURCE_Y:  src_y_q <= cfg_data_i[hs3_pkg::COORD_W-1:0];
          hs3_pkg::REG_SOURCE_Z:  src_z_q <= cfg_data_i[hs3_pkg::COORD_W-1:0];
        endcase
      end
      in_x_q    <= in_x_d;
      in_y_q    <= in_y_d;
      in_z_q    <= in_z_d;
      out_x_q   <= out_x_d;
      out_y_q   <= out_y_d;
      out_z_q   <= out_z_d;
      in_done_q <= in_done_d;
      v1_q      <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      meta1_q <= meta_d;
    end
  end

  hs3_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (shift),
    .restart_i(restart),
    .len_i    (len),
    .data_i   (in_ch.temperature_in),
    .taps_o   (taps)
  );

  hs3_update u_update (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v1_q),
    .ready_o(upd_ready),
    .taps_i (taps),
    .meta_i (meta1_q),
    .out_ch (out_ch)
  );

  // Draining only starts once the input position has reached the last voxel.
  a_done_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_done_q |-> ((in_x_q == n_m1) && (in_y_q == n_m1) && (in_z_q == n_m1)))
    else $error("draining while input position is not at the last voxel");

  // The tap stage only fills from a window shift.
  a_tap_from_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v1_q) |-> $past(shift))
    else $error("tap stage filled without a window shift");

  // Emitting the final voxel ends the sweep and rewinds all positions.
  a_sweep_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_last) |=> ((out_x_q == '0) && (out_y_q == '0) && (out_z_q == '0)
                            && (in_z_q == '0) && !in_done_q))
    else $error("positions not rewound after the final voxel");

  // A voxel item is never shifted in while the tap stage holds an unread voxel.
  a_no_tap_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shift && v1_q) |-> upd_ready)
    else $error("tap stage overwritten before it was consumed");

endmodule

### tb/heat_stencil_3d_sweep_test.sv
`timescale 1ns / 1ps

// Testbench for the 3D heat stencil sweep. An initial block fills a queue of
// pending items. A clocked driver sends them in bursts and updates a local
// model of the block whenever an item is accepted. A clocked monitor stalls
// on a pattern of its own and checks every result against the model.
module heat_stencil_3d_sweep_test;

  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 7;
  // Cycles to let pass after the last expected result. This covers the three
  // pipeline stages and leaves some margin.
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 800;
  localparam int BIG_EDGE = 16;
  localparam longint TIMEOUT_NS = 64'd500_000 * CLK_PERIOD;

  // Two planes plus one voxel, the same depth as the block's window.
  localparam int WIN_DEPTH = 2 * hs3_pkg::PLANE + 1;

  // Item kinds on the input channel.
  localparam logic MODE_VOXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic           mode;
    hs3_pkg::temp_t temp;
  } stim_item_t;

  typedef struct packed {
    hs3_pkg::temp_t temp;
    logic           last;
  } voxel_result_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [hs3_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [hs3_pkg::CFG_DATA_W-1:0] cfg_data_i;

  hs3_in_if  in_ch ();
  hs3_out_if out_ch ();

  heat_stencil_3d_sweep u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Items waiting to be offered, and updated voxels that the block owes us.
  stim_item_t    stim_q[$];
  voxel_result_t updated_voxels_q[$];
  int unsigned   fail_count;

  // Local copy of the block's registers and sweep position.
  logic [hs3_pkg::CFG_DATA_W-1:0] edge_reg;
  logic [hs3_pkg::COORD_W-1:0]    src_x, src_y, src_z;
  hs3_pkg::temp_t                 plane_mem [WIN_DEPTH];
  int unsigned                    in_x, in_y, in_z;
  int unsigned                    out_x, out_y, out_z;
  bit                             grid_received;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // The edge register saturates to the range the window can hold.
  function automatic int unsigned grid_n();
    if (edge_reg < 2) return 2;
    if (edge_reg > hs3_pkg::MAX_EDGE) return hs3_pkg::MAX_EDGE;
    return edge_reg;
  endfunction

  function automatic void sweep_restart();
    in_x = 0;
    in_y = 0;
    in_z = 0;
    out_x = 0;
    out_y = 0;
    out_z = 0;
    grid_received = 1'b0;
  endfunction

  function automatic hs3_pkg::temp_t window_at(int unsigned p);
    return plane_mem[p % WIN_DEPTH];
  endfunction

  // Computes the next voxel in raster order and moves the output position on.
  // A neighbor outside the grid is replaced by the center value, and the
  // source voxel keeps its temperature. The division by six rounds half up.
  function automatic voxel_result_t next_updated_voxel();
    int unsigned     n;
    int unsigned     nn;
    int unsigned     p;
    hs3_pkg::temp_t  centre;
    longint unsigned nbr_sum;
    voxel_result_t   res;
    n = grid_n();
    nn = n * n;
    p = (out_z * n + out_y) * n + out_x;
    centre = window_at(p);
    res.last = (out_x == n - 1) && (out_y == n - 1) && (out_z == n - 1);
    if (out_x == src_x && out_y == src_y && out_z == src_z) begin
      res.temp = centre;
    end else begin
      nbr_sum = 0;
      nbr_sum += (out_x > 0) ? window_at(p - 1) : centre;
      nbr_sum += (out_x < n - 1) ? window_at(p + 1) : centre;
      nbr_sum += (out_y > 0) ? window_at(p - n) : centre;
      nbr_sum += (out_y < n - 1) ? window_at(p + n) : centre;
      nbr_sum += (out_z > 0) ? window_at(p - nn) : centre;
      nbr_sum += (out_z < n - 1) ? window_at(p + nn) : centre;
      res.temp = hs3_pkg::temp_t'((nbr_sum + 3) / 6);
    end
    if (res.last) begin
      // The next voxel item opens a new sweep.
      sweep_restart();
    end else begin
      out_x = out_x + 1;
      if (out_x == n) begin
        out_x = 0;
        out_y = out_y + 1;
        if (out_y == n) begin
          out_y = 0;
          out_z = out_z + 1;
        end
      end
    end
    return res;
  endfunction

  // Applies one accepted item to the model and queues the result it causes.
  // A flush only drains once the whole grid is in; a voxel arriving while
  // the block drains is dropped.
  function automatic void predict_item(logic mode, hs3_pkg::temp_t t);
    int unsigned n;
    int unsigned idx;
    n = grid_n();
    if (mode == MODE_FLUSH) begin
      if (grid_received) updated_voxels_q.push_back(next_updated_voxel());
      return;
    end
    if (grid_received) return;
    idx = (in_z * n + in_y) * n + in_x;
    plane_mem[idx % WIN_DEPTH] = t;
    if (idx == n * n * n - 1) begin
      grid_received = 1'b1;
    end else begin
      in_x = in_x + 1;
      if (in_x == n) begin
        in_x = 0;
        in_y = in_y + 1;
        if (in_y == n) begin
          in_y = 0;
          in_z = in_z + 1;
        end
      end
    end
    // The voxel one plane back now has its upper-z neighbor.
    if (idx >= n * n) updated_voxels_q.push_back(next_updated_voxel());
  endfunction

  // ------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps between them. About a
  // quarter of the bursts are long and gapless.
  // ------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;
  stim_item_t  next_item;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_item(in_ch.mode, in_ch.temperature_in);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          next_item = stim_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= next_item.mode;
          in_ch.temperature_in <= next_item.temp;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(40, 120);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 16);
              gap_left = $urandom_range(1, 6);
            end
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: ready follows a repeating pattern, always high for the first
  // third and random after that. Twice during the run it holds ready low for
  // a long stretch, so that the pipeline fills and the block stalls its input.
  // ------------------------------------------------------------------------
  int unsigned   rx_cycle;
  int unsigned   hold_left;
  int unsigned   results_seen;
  voxel_result_t want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_cycle = 0;
      hold_left = 0;
      results_seen = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen = results_seen + 1;
        if (updated_voxels_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual temperature_out %h %s %b",
                   $time, out_ch.temperature_out, "last_voxel", out_ch.last_voxel);
          fail_count = fail_count + 1;
        end else begin
          want = updated_voxels_q.pop_front();
          if (out_ch.temperature_out !== want.temp) begin
            $display("%0t: temperature_out mismatch, expected %h, actual %h",
                     $time, want.temp, out_ch.temperature_out);
            fail_count = fail_count + 1;
          end
          if (out_ch.last_voxel !== want.last) begin
            $display("%0t: last_voxel mismatch, expected %b, actual %b",
                     $time, want.last, out_ch.last_voxel);
            fail_count = fail_count + 1;
          end
        end
        if (results_seen == 200 || results_seen == 500) hold_left = LONG_HOLD_CYCLES;
      end
      rx_cycle = (rx_cycle + 1) % 96;
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_cycle < 32) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  function automatic hs3_pkg::temp_t random_temp();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return hs3_pkg::temp_t'($urandom());
    endcase
  endfunction

  function automatic void push_item(logic mode, hs3_pkg::temp_t t);
    stim_item_t item;
    item.mode = mode;
    item.temp = t;
    stim_q.push_back(item);
  endfunction

  // Queues one sweep: every voxel, then one flush per voxel of the last
  // plane. Now and then an item that the block must drop is mixed in: a
  // flush while voxels still stream, a voxel while the block drains, or a
  // flush after the sweep has ended. A broken sweep stops at a random point.
  // Returns the number of items that belong to the sweep proper.
  function automatic int unsigned queue_sweep(int unsigned n, bit broken);
    int unsigned vox_total;
    int unsigned seq_len;
    int unsigned k;
    vox_total = n * n * n;
    seq_len = vox_total + n * n;
    if (broken) seq_len = $urandom_range(1, seq_len - 1);
    for (k = 0; k < seq_len; k++) begin
      if ($urandom_range(0, 39) == 0) begin
        push_item((k < vox_total) ? MODE_FLUSH : MODE_VOXEL, random_temp());
      end
      push_item((k < vox_total) ? MODE_VOXEL : MODE_FLUSH, random_temp());
    end
    if (!broken && $urandom_range(0, 3) == 0) push_item(MODE_FLUSH, random_temp());
    return seq_len;
  endfunction

  // Writes one register; the model copy follows at the same time, which is
  // safe because registers are only written while the block is idle.
  task automatic write_reg(hs3_pkg::cfg_reg_e idx, logic [hs3_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      hs3_pkg::REG_EDGE_SIZE: begin
        edge_reg = value;
        sweep_restart();
      end
      hs3_pkg::REG_SOURCE_X: src_x = value[hs3_pkg::COORD_W-1:0];
      hs3_pkg::REG_SOURCE_Y: src_y = value[hs3_pkg::COORD_W-1:0];
      hs3_pkg::REG_SOURCE_Z: src_z = value[hs3_pkg::COORD_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [hs3_pkg::CFG_DATA_W-1:0] edge_val,
                           logic [hs3_pkg::CFG_DATA_W-1:0] sx,
                           logic [hs3_pkg::CFG_DATA_W-1:0] sy,
                           logic [hs3_pkg::CFG_DATA_W-1:0] sz);
    write_reg(hs3_pkg::REG_EDGE_SIZE, edge_val);
    write_reg(hs3_pkg::REG_SOURCE_X, sx);
    write_reg(hs3_pkg::REG_SOURCE_Y, sy);
    write_reg(hs3_pkg::REG_SOURCE_Z, sz);
    // Start queuing away from the clock edge at which the driver pops.
    @(negedge clk_i);
  endtask

  // Waits until every item has been sent and every expected result has
  // arrived, then lets the pipeline settle.
  task automatic wait_idle();
    while (stim_q.size() != 0 || in_ch.valid || updated_voxels_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Picks a source coordinate: mostly inside the grid, sometimes at the
  // extremes, and sometimes with the unused upper data bit set.
  function automatic logic [hs3_pkg::CFG_DATA_W-1:0] random_source(int unsigned n);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return hs3_pkg::CFG_DATA_W'(63);
      2:       return hs3_pkg::CFG_DATA_W'($urandom_range(64, 127));
      default: return hs3_pkg::CFG_DATA_W'($urandom_range(0, n - 1));
    endcase
  endfunction

  int unsigned random_count;
  int unsigned edge_pick;
  int unsigned k;
  bit          broken;
  bit          need_restart;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = hs3_pkg::REG_EDGE_SIZE;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_VOXEL;
    in_ch.temperature_in = '0;
    out_ch.ready = 1'b0;
    fail_count = 0;

    // Model state after reset: edge 64 and the source at (2,2,2).
    edge_reg = hs3_pkg::CFG_DATA_W'(hs3_pkg::MAX_EDGE);
    src_x = hs3_pkg::COORD_W'(2);
    src_y = hs3_pkg::COORD_W'(2);
    src_z = hs3_pkg::COORD_W'(2);
    sweep_restart();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Edge 0 saturates to 2, source at the origin. A flush before any voxel
    // and a voxel during the drain are both dropped, as is the flush after
    // the sweep has ended.
    configure('0, '0, '0, '0);
    push_item(MODE_FLUSH, '1);
    push_item(MODE_VOXEL, '0);
    push_item(MODE_VOXEL, '1);
    push_item(MODE_VOXEL, '1);
    push_item(MODE_VOXEL, '0);
    push_item(MODE_VOXEL, hs3_pkg::temp_t'(1));
    push_item(MODE_VOXEL, hs3_pkg::temp_t'(25'h1555555));
    push_item(MODE_VOXEL, hs3_pkg::temp_t'(25'h0AAAAAA));
    push_item(MODE_VOXEL, '1);
    push_item(MODE_VOXEL, '1);
    for (k = 0; k < 4; k++) push_item(MODE_FLUSH, '0);
    push_item(MODE_FLUSH, '0);

    // Edge 1 also saturates to 2; the source lies outside the grid. A grid at
    // full scale must come back at full scale without overflow.
    wait_idle();
    configure(hs3_pkg::CFG_DATA_W'(1), hs3_pkg::CFG_DATA_W'(63), hs3_pkg::CFG_DATA_W'(63),
              hs3_pkg::CFG_DATA_W'(63));
    for (k = 0; k < 8; k++) push_item(MODE_VOXEL, '1);
    for (k = 0; k < 4; k++) push_item(MODE_FLUSH, '0);

    // A larger grid. One full plane and a bit more covers the long delay
    // lines, the far x boundary and a source voxel.
    wait_idle();
    configure(hs3_pkg::CFG_DATA_W'(BIG_EDGE), hs3_pkg::CFG_DATA_W'(5), hs3_pkg::CFG_DATA_W'(1),
              hs3_pkg::CFG_DATA_W'(0));
    for (k = 0; k < BIG_EDGE * BIG_EDGE + 40; k++) push_item(MODE_VOXEL, random_temp());

    // Random part: mostly complete sweeps on small grids with random
    // temperatures. Broken sweeps are followed by a new edge write, which
    // restarts the block, and once in a while the sender waits for every
    // result before going on.
    random_count = 0;
    need_restart = 1'b1;
    while (random_count < RANDOM_ITEMS) begin
      if (need_restart || $urandom_range(0, 4) == 0) begin
        wait_idle();
        edge_pick = $urandom_range(0, 19);
        if (edge_pick == 0) edge_pick = $urandom_range(0, 1);
        else if (edge_pick == 1) edge_pick = $urandom_range(6, 8);
        else edge_pick = $urandom_range(2, 5);
        configure(hs3_pkg::CFG_DATA_W'(edge_pick), random_source(edge_pick < 2 ? 2 : edge_pick),
                  random_source(edge_pick < 2 ? 2 : edge_pick),
                  random_source(edge_pick < 2 ? 2 : edge_pick));
      end else if ($urandom_range(0, 9) == 0) begin
        wait_idle();
        @(negedge clk_i);
      end else begin
        @(negedge clk_i);
      end
      broken = ($urandom_range(0, 9) == 0);
      random_count += queue_sweep(grid_n(), broken);
      need_restart = broken;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hang: this is many times the length of a correct run.
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout, %0d items unsent, %0d results outstanding",
             $time, stim_q.size(), updated_voxels_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
